[rtl/cqrt_pkg.sv]
`default_nettype none
package cqrt_pkg;

  localparam int unsigned STEP_W = 16;
  localparam int unsigned DIVISOR_W = 17;
  localparam int unsigned BIAS_W = 20;
  localparam int unsigned FAC_W = 8;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [FAC_W-1:0] FAC_EDGE_LIMIT = 8'd160;

  // floor(t / 3) == (t * RECIP3) >> 17 for every 16-bit t
  localparam logic [STEP_W-1:0] RECIP3 = 16'hAAAB;
  // floor(2 * t / 5) == (t * RECIP25) >> 19 for every 16-bit t
  localparam logic [STEP_W+1:0] RECIP25 = 18'd209716;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_IS_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IS_CHROMA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSSLESS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PSY_INTRA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PSY_PRED = 3'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b00_0001,
    S_TSET = 6'b00_0010,
    S_PROD = 6'b00_0100,
    S_QDIV = 6'b00_1000,
    S_REC  = 6'b01_0000,
    S_OUT  = 6'b10_0000
  } state_e;

  typedef struct packed {
    logic load;
    logic tset;
    logic prod;
    logic q_start;
    logic rec;
    logic out;
  } cmd_t;

  typedef struct packed {
    logic lossless;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/coef_quantize_run_tokenizer_core.sv]
// Coefficient quantizer and zero-run tokenizer.
// Input channel: in_valid_i / in_stall_o with one wavelet coefficient and its
// side fields per transaction. Output channel: out_valid_o / out_stall_i with
// level, saturated reconstruction, token flag, zero run, token total and
// plane end. One result per input transaction.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 frame_is_p,
// 1 is_chroma, 2 lossless, 3 psy_intra_masking, 4 psy_pred_masking); write
// only while no transaction is in flight.
// Lossless items go from acceptance straight to the output state.
// Otherwise the step adjustment uses shifts and reciprocal multiplies, and one
// restoring divider, one quotient bit per cycle, runs for the quantizer on
// W-bit dividends, W = max(COEF_BITS,20)+2.
// One item is in work at a time. The next item is accepted the cycle after
// its predecessor lands in the output register. A stalled result holds;
// the block then finishes the next item and waits for the output register
// to free up.
// Reset clears the configuration, the run and token counters and marks the
// start of a plane, so the first coefficient is coded as zero.
`default_nettype none
module coef_quantize_run_tokenizer_core #(
  parameter int unsigned COEF_BITS = 16,
  parameter int unsigned RUN_FIELD_BITS = 20,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cqrt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                          cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [COEF_BITS-1:0]   coef_i,
  input  wire logic [15:0]                   quant_step_i,
  input  wire logic [1:0]                    band_i,
  input  wire logic [1:0]                    level_i,
  input  wire logic                          stable_flag_i,
  input  wire logic                          maintain_flag_i,
  input  wire logic                          ringing_flag_i,
  input  wire logic                          simple_complex_flag_i,
  input  wire logic signed [COEF_BITS-1:0]   parent_coef_i,
  input  wire logic [7:0]                    mask_factor_i,
  input  wire logic                          last_coef_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic signed [COEF_BITS-1:0]        quant_level_o,
  output logic signed [COEF_BITS-1:0]        recon_value_o,
  output logic                               token_valid_o,
  output logic [RUN_FIELD_BITS-1:0]          zero_run_o,
  output logic [COUNT_BITS-1:0]              token_total_o,
  output logic                               plane_end_o
);

  cqrt_pkg::cmd_t cmd;
  cqrt_pkg::status_t status;

  cqrt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  cqrt_dp #(
    .COEF_BITS     (COEF_BITS),
    .RUN_FIELD_BITS(RUN_FIELD_BITS),
    .COUNT_BITS    (COUNT_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .coef_i               (coef_i),
    .quant_step_i         (quant_step_i),
    .band_i               (band_i),
    .level_i              (level_i),
    .stable_flag_i        (stable_flag_i),
    .maintain_flag_i      (maintain_flag_i),
    .ringing_flag_i       (ringing_flag_i),
    .simple_complex_flag_i(simple_complex_flag_i),
    .parent_coef_i        (parent_coef_i),
    .mask_factor_i        (mask_factor_i),
    .last_coef_i          (last_coef_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .quant_level_o        (quant_level_o),
    .recon_value_o        (recon_value_o),
    .token_valid_o        (token_valid_o),
    .zero_run_o           (zero_run_o),
    .token_total_o        (token_total_o),
    .plane_end_o          (plane_end_o),
    .cmd_i                (cmd),
    .status_o             (status)
  );

endmodule
`default_nettype wire

[rtl/cqrt_div.sv]
`default_nettype none
module cqrt_div #(
  parameter int unsigned NUM_W = 22,
  parameter int unsigned DEN_W = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] dividend_i,
  input  wire logic [DEN_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] rem_q, rem_d, den_q, den_d;
  logic [DEN_W:0]   trial;

  assign trial = {rem_q, quo_q[NUM_W-1]} - {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      quo_d = dividend_i;
      rem_d = '0;
      den_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      // restoring step: keep the trial remainder when it did not go negative
      if (!trial[DEN_W]) begin
        rem_d = trial[DEN_W-1:0];
        quo_d = {quo_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[DEN_W-2:0], quo_q[NUM_W-1]};
        quo_d = {quo_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

[rtl/cqrt_ctrl.sv]
`default_nettype none
module cqrt_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire cqrt_pkg::status_t status_i,
  output cqrt_pkg::cmd_t        cmd_o
);

  cqrt_pkg::state_e state_q, state_d;

  assign in_stall_o = (state_q != cqrt_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      cqrt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = status_i.lossless ? cqrt_pkg::S_OUT : cqrt_pkg::S_TSET;
        end
      end
      cqrt_pkg::S_TSET: begin
        cmd_o.tset = 1'b1;
        state_d = cqrt_pkg::S_PROD;
      end
      cqrt_pkg::S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d = cqrt_pkg::S_QDIV;
      end
      cqrt_pkg::S_QDIV: begin
        // launches the quantizer division once the divider is idle
        if (!status_i.div_busy) begin
          cmd_o.q_start = 1'b1;
          state_d = cqrt_pkg::S_REC;
        end
      end
      cqrt_pkg::S_REC: begin
        if (!status_i.div_busy) begin
          cmd_o.rec = 1'b1;
          state_d = cqrt_pkg::S_OUT;
        end
      end
      cqrt_pkg::S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out = 1'b1;
          state_d = cqrt_pkg::S_IDLE;
        end
      end
      default: state_d = cqrt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cqrt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[rtl/cqrt_dp.sv]
`default_nettype none
module cqrt_dp #(
  parameter int unsigned COEF_BITS = 16,
  parameter int unsigned RUN_FIELD_BITS = 20,
  parameter int unsigned COUNT_BITS = 24
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [cqrt_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic                          cfg_data_i,
  input  wire logic signed [COEF_BITS-1:0]   coef_i,
  input  wire logic [15:0]                   quant_step_i,
  input  wire logic [1:0]                    band_i,
  input  wire logic [1:0]                    level_i,
  input  wire logic                          stable_flag_i,
  input  wire logic                          maintain_flag_i,
  input  wire logic                          ringing_flag_i,
  input  wire logic                          simple_complex_flag_i,
  input  wire logic signed [COEF_BITS-1:0]   parent_coef_i,
  input  wire logic [7:0]                    mask_factor_i,
  input  wire logic                          last_coef_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic signed [COEF_BITS-1:0]        quant_level_o,
  output logic signed [COEF_BITS-1:0]        recon_value_o,
  output logic                               token_valid_o,
  output logic [RUN_FIELD_BITS-1:0]          zero_run_o,
  output logic [COUNT_BITS-1:0]              token_total_o,
  output logic                               plane_end_o,
  input  wire cqrt_pkg::cmd_t                cmd_i,
  output cqrt_pkg::status_t                  status_o
);

  localparam int unsigned BW = cqrt_pkg::BIAS_W;
  localparam int unsigned NW = ((COEF_BITS > BW) ? COEF_BITS : BW) + 2;
  localparam int unsigned SW = cqrt_pkg::STEP_W;
  localparam int unsigned RW = COEF_BITS + SW + 1;
  localparam int unsigned M3W = 2 * SW;
  localparam int unsigned M25W = 2 * SW + 2;
  localparam logic [NW-1:0] LIM_N = NW'(1) << (COEF_BITS - 1);
  localparam logic [RW-1:0] LIM_R = RW'(1) << (COEF_BITS - 1);
  localparam logic signed [COEF_BITS-1:0] POS_MAX = COEF_BITS'((1 << (COEF_BITS - 1)) - 1);
  localparam logic signed [COEF_BITS-1:0] NEG_MIN = COEF_BITS'(1) << (COEF_BITS - 1);

  // configuration
  logic frame_p_q, chroma_q, lossless_q, psy_intra_q, psy_pred_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_p_q <= 1'b0;
      chroma_q <= 1'b0;
      lossless_q <= 1'b0;
      psy_intra_q <= 1'b0;
      psy_pred_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cqrt_pkg::CFG_FRAME_IS_P: frame_p_q <= cfg_data_i;
        cqrt_pkg::CFG_IS_CHROMA:  chroma_q <= cfg_data_i;
        cqrt_pkg::CFG_LOSSLESS:   lossless_q <= cfg_data_i;
        cqrt_pkg::CFG_PSY_INTRA:  psy_intra_q <= cfg_data_i;
        cqrt_pkg::CFG_PSY_PRED:   psy_pred_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // captured transaction
  logic signed [COEF_BITS-1:0] v_q, parc_q;
  logic [SW-1:0] step_q;
  logic [1:0] band_q, lvl_q;
  logic st_q, mt_q, rg_q, sc_q, last_q;
  logic [7:0] fac_q;
  logic start_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q <= start_q ? '0 : coef_i;
      parc_q <= parent_coef_i;
      step_q <= quant_step_i;
      band_q <= band_i;
      lvl_q <= level_i;
      st_q <= stable_flag_i;
      mt_q <= maintain_flag_i;
      rg_q <= ringing_flag_i;
      sc_q <= simple_complex_flag_i;
      fac_q <= mask_factor_i;
      last_q <= last_coef_i;
    end
  end

  // intra step adjustment: shifts and reciprocal multiplies by small constants
  logic parc_nz;
  logic [1:0] sel;
  logic [M3W-1:0] mul3;
  logic [M25W-1:0] mul25;
  logic [SW-1:0] div3, div6, two5, t_raw;

  assign parc_nz = (parc_q != '0);
  assign sel = {mt_q, st_q};
  assign mul3 = M3W'(step_q) * M3W'(cqrt_pkg::RECIP3);
  assign mul25 = M25W'(step_q) * M25W'(cqrt_pkg::RECIP25);
  assign div3 = {1'b0, mul3[M3W-1:17]};
  assign div6 = {2'b0, mul3[M3W-1:18]};
  assign two5 = {1'b0, mul25[M25W-1:19]};

  always_comb begin
    t_raw = step_q;
    if (band_q != 2'd0 && !frame_p_q && lvl_q != 2'd0) begin
      if (sel == 2'b10) begin
        if (rg_q) t_raw = step_q >> 2;
        else if (!parc_nz) t_raw = step_q >> 1;
      end else if (lvl_q == 2'd2) begin
        if (sel == 2'b01) t_raw = parc_nz ? (step_q >> 2) : div3;
        else if (sel == 2'b11) t_raw = parc_nz ? div6 : (step_q >> 3);
      end else begin
        if (sel == 2'b01) t_raw = parc_nz ? div3 : two5;
        else if (sel == 2'b11) t_raw = parc_nz ? (step_q >> 2) : div6;
      end
    end
  end

  // quantizer divider
  logic div_start, div_busy;
  logic [NW-1:0] div_num, quo;
  logic [cqrt_pkg::DIVISOR_W-1:0] div_den;
  logic [NW-1:0] n_abs;
  logic [SW-1:0] t_q;

  assign div_start = cmd_i.q_start;
  assign div_num = n_abs;
  assign div_den = {t_q, 1'b0};

  cqrt_div #(
    .NUM_W(NW),
    .DEN_W(cqrt_pkg::DIVISOR_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_num),
    .divisor_i (div_den),
    .busy_o    (div_busy),
    .quotient_o(quo)
  );

  // adjusted step, floored at one
  always_ff @(posedge clk_i) begin
    if (cmd_i.tset) t_q <= (t_raw == '0) ? SW'(1) : t_raw;
  end

  // masking product
  logic v_pos, v_neg, p_pos, p_neg, edge_m, fac_drop;
  logic [cqrt_pkg::PROD_W-1:0] prod_q;

  assign v_pos = (v_q > 0);
  assign v_neg = v_q[COEF_BITS-1];
  assign p_pos = (parc_q > 0);
  assign p_neg = parc_q[COEF_BITS-1];
  assign edge_m = (v_pos == p_pos) && (v_neg == p_neg);
  assign fac_drop = !frame_p_q && !rg_q && edge_m && (fac_q >= cqrt_pkg::FAC_EDGE_LIMIT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod) prod_q <= t_q * (fac_drop ? 8'd0 : fac_q);
  end

  // bias by quantizer mode
  logic signed [BW-1:0] te, sh2, sh3, pr8, bias;
  assign te = BW'(t_q);
  assign sh2 = te >>> 2;
  assign sh3 = te >>> 3;
  assign pr8 = BW'(prod_q >> 8);

  always_comb begin
    bias = '0;
    if (band_q == 2'd0 || chroma_q) begin
      if (frame_p_q) bias = '0;
      else if (chroma_q) bias = BW'((te * 3 + 2) >>> 2);
      else if (band_q == 2'd0) bias = te;
      else bias = BW'((te * 3 + 4) >>> 3);
    end else if (frame_p_q) begin
      if (psy_pred_q) bias = sc_q ? (-sh2 - pr8) : (sh2 - pr8);
      else bias = '0;
    end else if (psy_intra_q) begin
      if (rg_q || edge_m || parc_nz) bias = pr8 + sh2;
      else bias = pr8 + sh3;
    end else begin
      bias = BW'((te * 3 + 4) >>> 3);
    end
  end

  logic signed [NW-1:0] v_abs, n_sum;
  logic qneg_q;
  assign v_abs = v_neg ? -NW'(v_q) : NW'(v_q);
  assign n_sum = v_abs + NW'(bias);
  assign n_abs = n_sum[NW-1] ? -n_sum : n_sum;

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_start) qneg_q <= v_neg ^ n_sum[NW-1];
  end

  // reconstruction product on clipped magnitude
  logic [COEF_BITS-1:0] m_clip;
  logic [COEF_BITS:0] k;
  logic [RW-1:0] rprod_q;
  assign m_clip = (quo >= LIM_N) ? LIM_N[COEF_BITS-1:0] : quo[COEF_BITS-1:0];
  assign k = {m_clip, frame_p_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.rec) rprod_q <= RW'(k) * RW'(t_q);
  end

  // result
  logic signed [COEF_BITS-1:0] lv, rec;
  logic tok;

  always_comb begin
    if (lossless_q) begin
      lv = v_q;
      rec = v_q;
    end else if (quo == '0) begin
      lv = '0;
      rec = '0;
    end else if (!qneg_q) begin
      lv = (quo > LIM_N - 1'b1) ? POS_MAX : quo[COEF_BITS-1:0];
      rec = (rprod_q > LIM_R - 1'b1) ? POS_MAX : rprod_q[COEF_BITS-1:0];
    end else begin
      lv = (quo >= LIM_N) ? NEG_MIN : -quo[COEF_BITS-1:0];
      rec = (rprod_q >= LIM_R) ? NEG_MIN : -rprod_q[COEF_BITS-1:0];
    end
  end
  assign tok = (lv != '0);

  logic [RUN_FIELD_BITS-1:0] zc_q;
  logic [COUNT_BITS-1:0] tc_q, tc_next;
  logic out_valid_q;

  assign tc_next = (tok && tc_q != '1) ? tc_q + 1'b1 : tc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zc_q <= '0;
      tc_q <= '0;
      start_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.out) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          zc_q <= '0;
          tc_q <= '0;
          start_q <= 1'b1;
        end else begin
          start_q <= 1'b0;
          tc_q <= tc_next;
          if (tok) zc_q <= '0;
          else if (zc_q != '1) zc_q <= zc_q + 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out) begin
      quant_level_o <= lv;
      recon_value_o <= rec;
      token_valid_o <= tok;
      zero_run_o <= tok ? zc_q : '0;
      token_total_o <= tc_next;
      plane_end_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o.lossless = lossless_q;
  assign status_o.div_busy = div_busy;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  a_run_only_with_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !token_valid_o |-> zero_run_o == '0)
    else $error("zero run reported without a token");
  a_token_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_valid_o |-> quant_level_o != '0)
    else $error("token with zero level");
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out |-> !out_valid_q || !out_stall_i)
    else $error("pending result overwritten");

endmodule
`default_nettype wire
